// ----- rtl/vcr_pkg.sv -----
// Shared constants, types and constant functions for the velocity corner radius unit.
// Depends on nothing; every other file imports it.
package vcr_pkg;

  localparam int VEL_W      = 24;
  localparam int RAD_W      = 16;
  localparam int VREF_W     = 24;
  localparam int GAM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // speed path
  localparam int SQS_W          = 48;
  localparam int SPD_W          = 24;
  localparam int SPD_SQRT_STEPS = 24;
  localparam int K_FRAC         = 16;
  localparam int K_W            = K_FRAC + 1;
  localparam int SPEED_LAT      = 2 + SPD_SQRT_STEPS + K_FRAC;

  // power path
  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam int M_W       = 31;
  localparam int POWER_LAT = 1 + LOG_STEPS + 2 + EXP_STEPS + 1;

  // lead path
  localparam int U_W             = 15;
  localparam int P_W             = U_W + 1;
  localparam int Q_W             = 31;
  localparam int DIV_STEPS       = 31;
  localparam int LEAD_SQRT_STEPS = 16;
  localparam int LEAD_W          = 16;
  localparam int LEAD_LAT        = 2 + DIV_STEPS + LEAD_SQRT_STEPS;
  localparam int LEAD_DLY        = SPEED_LAT + POWER_LAT - LEAD_LAT;

  // input register + speed + power + two multiplies + output register
  localparam int PIPE_DEPTH = 1 + SPEED_LAT + POWER_LAT + 3;

  localparam logic [GAM_W-1:0]  GAMMA_ONE = GAM_W'(4096);
  localparam logic [VREF_W-1:0] VREF_MIN  = VREF_W'(256);
  localparam logic [K_W-1:0]    K_ONE     = K_W'(65536);
  localparam logic [LEAD_W-1:0] LEAD_MAX  = LEAD_W'(32768);

  localparam logic [RAD_W-1:0]  REST_RST  = RAD_W'(2048);
  localparam logic [RAD_W-1:0]  MIN_RST   = RAD_W'(0);
  localparam logic [RAD_W-1:0]  MAX_RST   = RAD_W'(65535);
  localparam logic [RAD_W-1:0]  SPRD_RST  = RAD_W'(1024);
  localparam logic [VREF_W-1:0] VREF_RST  = VREF_W'(256000);
  localparam logic [GAM_W-1:0]  GAMMA_RST = GAM_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST   = 3'd0,
    REG_MIN    = 3'd1,
    REG_MAX    = 3'd2,
    REG_SPREAD = 3'd3,
    REG_VREF   = 3'd4,
    REG_GAMMA  = 3'd5
  } cfg_reg_t;

  // per-item flags that ride alongside the arithmetic
  typedef struct packed {
    logic zero;
    logic sum_neg;
    logic sum_pos;
    logic dif_neg;
    logic dif_pos;
  } side_t;

  typedef struct packed {
    logic [LEAD_W-1:0] lsum;
    logic [LEAD_W-1:0] ldif;
  } lead_t;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem;
    longint unsigned r;
    longint unsigned b;
    rem = v;
    r   = 0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-idx) in Q1.30, each one the floored root of the one before
  function automatic logic [M_W-1:0] exp_coef(input int idx);
    longint unsigned c;
    c = isqrt64(64'd1 << 59);
    for (int j = 1; j < idx; j++) begin
      c = isqrt64(c << 30);
    end
    return c[M_W-1:0];
  endfunction

endpackage

// ----- rtl/vcr_speed.sv -----
// Speed magnitude (pipelined square root) and linear liquidity (pipelined divider).
// Depends on vcr_pkg.
module vcr_speed
  import vcr_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [VEL_W-1:0]  mag_x,
  input  logic [VEL_W-1:0]  mag_y,
  input  logic [VREF_W-1:0] vref,
  output logic [K_W-1:0]    k_lin
);

  logic [SQS_W-1:0]  sqx_r;
  logic [SQS_W-1:0]  sqy_r;
  logic [SQS_W-1:0]  sum_r;
  logic [SQS_W-1:0]  rem_r  [SPD_SQRT_STEPS];
  logic [SQS_W-1:0]  root_r [SPD_SQRT_STEPS];
  logic [VREF_W-1:0] dr_r   [K_FRAC];
  logic [K_FRAC-1:0] quo_r  [K_FRAC];
  logic              ge_r   [K_FRAC];
  logic [SPD_W-1:0]  speed;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= SQS_W'({24'b0, mag_x} * {24'b0, mag_x});
      sqy_r <= SQS_W'({24'b0, mag_y} * {24'b0, mag_y});
      sum_r <= sqx_r + sqy_r;
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SPD_SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [SQS_W-1:0] BIT = SQS_W'(1) << (2 * (SPD_SQRT_STEPS - 1 - i));
    logic [SQS_W-1:0] v_in;
    logic [SQS_W-1:0] r_in;
    logic [SQS_W-1:0] t;
    if (i == 0) begin : g_first
      assign v_in = sum_r;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = rem_r[i-1];
      assign r_in = root_r[i-1];
    end
    assign t = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= t) begin
          rem_r[i]  <= v_in - t;
          root_r[i] <= (r_in >> 1) + BIT;
        end else begin
          rem_r[i]  <= v_in;
          root_r[i] <= r_in >> 1;
        end
      end
    end
  end

  assign speed = root_r[SPD_SQRT_STEPS-1][SPD_W-1:0];

  // restoring divide of speed*2^16 by vref, one quotient bit per stage
  for (genvar j = 0; j < K_FRAC; j++) begin : g_div
    logic [VREF_W-1:0] r_in;
    logic [K_FRAC-1:0] q_in;
    logic              ge_in;
    logic [VREF_W:0]   r2;
    if (j == 0) begin : g_first
      assign r_in  = speed;
      assign q_in  = '0;
      assign ge_in = (speed >= vref);
    end else begin : g_next
      assign r_in  = dr_r[j-1];
      assign q_in  = quo_r[j-1];
      assign ge_in = ge_r[j-1];
    end
    assign r2 = {r_in, 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        ge_r[j] <= ge_in;
        if (r2 >= {1'b0, vref}) begin
          dr_r[j]  <= VREF_W'(r2 - {1'b0, vref});
          quo_r[j] <= {q_in[K_FRAC-2:0], 1'b1};
        end else begin
          dr_r[j]  <= r2[VREF_W-1:0];
          quo_r[j] <= {q_in[K_FRAC-2:0], 1'b0};
        end
      end
    end
  end

  assign k_lin = ge_r[K_FRAC-1] ? K_ONE : {1'b0, quo_r[K_FRAC-1]};

endmodule

// ----- rtl/vcr_power.sv -----
// Liquidity power stage: log2 by repeated squaring, scale by exponent, exp2 by products.
// Depends on vcr_pkg (exp2 coefficient function).
module vcr_power
  import vcr_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [K_W-1:0]   k_lin,
  input  logic [GAM_W-1:0] gamma,
  output logic [K_W-1:0]   k_out
);

  logic [3:0]        msb;
  logic [M_W-1:0]    m0;
  logic              byp;
  logic [K_W-1:0]    bval;

  logic [M_W-1:0]    m0_r;
  logic [3:0]        p0_r;
  logic              byp_r  [POWER_LAT];
  logic [K_W-1:0]    bval_r [POWER_LAT];

  logic [M_W-1:0]    lm_r    [LOG_STEPS];
  logic [K_FRAC-1:0] lfrac_r [LOG_STEPS];
  logic [3:0]        lp_r    [LOG_STEPS];

  logic [20:0]       n_r;
  logic [36:0]       e_prod;
  logic [7:0]        ip_r;
  logic [K_FRAC-1:0] f_r;

  logic [M_W-1:0]    acc_r [EXP_STEPS];
  logic [7:0]        xip_r [EXP_STEPS];
  logic [K_FRAC-1:0] xf_r  [EXP_STEPS];

  logic [4:0]        shamt;
  logic [M_W-1:0]    shifted;
  logic [K_W-1:0]    kpow_r;

  always_comb begin
    msb = '0;
    for (int b = 0; b < K_FRAC; b++) begin
      if (k_lin[b]) msb = 4'(b);
    end
  end

  assign m0   = {15'b0, k_lin[K_FRAC-1:0]} << (5'd30 - {1'b0, msb});
  assign byp  = (gamma == '0) || (gamma == GAMMA_ONE) || (k_lin == '0) || k_lin[K_FRAC];
  assign bval = (gamma == '0) ? K_ONE : k_lin;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r      <= m0;
      p0_r      <= msb;
      byp_r[0]  <= byp;
      bval_r[0] <= bval;
      for (int s = 1; s < POWER_LAT; s++) begin
        byp_r[s]  <= byp_r[s-1];
        bval_r[s] <= bval_r[s-1];
      end
    end
  end

  // log2: square the mantissa, renormalize, one fraction bit per stage
  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    logic [M_W-1:0]    m_in;
    logic [K_FRAC-1:0] f_in;
    logic [3:0]        p_in;
    logic [61:0]       sq;
    if (g == 0) begin : g_first
      assign m_in = m0_r;
      assign f_in = '0;
      assign p_in = p0_r;
    end else begin : g_next
      assign m_in = lm_r[g-1];
      assign f_in = lfrac_r[g-1];
      assign p_in = lp_r[g-1];
    end
    assign sq = {31'b0, m_in} * {31'b0, m_in};
    always_ff @(posedge clk) begin
      if (en) begin
        lp_r[g] <= p_in;
        if (sq[61]) begin
          lm_r[g]    <= sq[61:31];
          lfrac_r[g] <= f_in | (K_FRAC'(1) << (K_FRAC - 1 - g));
        end else begin
          lm_r[g]    <= sq[60:30];
          lfrac_r[g] <= f_in;
        end
      end
    end
  end

  assign e_prod = {16'b0, n_r} * {21'b0, gamma};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= {5'd16 - {1'b0, lp_r[LOG_STEPS-1]}, 16'b0} - {5'b0, lfrac_r[LOG_STEPS-1]};
      ip_r <= e_prod[35:28];
      f_r  <= e_prod[27:12];
    end
  end

  // exp2 of the fraction: multiply in 2^(-2^-i) where fraction bit i is set
  for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
    localparam logic [M_W-1:0] COEF = exp_coef(g + 1);
    logic [M_W-1:0]    a_in;
    logic [7:0]        ip_in;
    logic [K_FRAC-1:0] f_in;
    logic [61:0]       prod;
    if (g == 0) begin : g_first
      assign a_in  = M_W'(1) << 30;
      assign ip_in = ip_r;
      assign f_in  = f_r;
    end else begin : g_next
      assign a_in  = acc_r[g-1];
      assign ip_in = xip_r[g-1];
      assign f_in  = xf_r[g-1];
    end
    assign prod = {31'b0, a_in} * {31'b0, COEF};
    always_ff @(posedge clk) begin
      if (en) begin
        xip_r[g] <= ip_in;
        xf_r[g]  <= f_in;
        acc_r[g] <= f_in[K_FRAC-1-g] ? prod[60:30] : a_in;
      end
    end
  end

  assign shamt   = 5'd14 + xip_r[EXP_STEPS-1][4:0];
  assign shifted = acc_r[EXP_STEPS-1] >> shamt;

  always_ff @(posedge clk) begin
    if (en) begin
      kpow_r <= (xip_r[EXP_STEPS-1] > 8'd16) ? '0 : shifted[K_W-1:0];
    end
  end

  assign k_out = byp_r[POWER_LAT-1] ? bval_r[POWER_LAT-1] : kpow_r;

endmodule

// ----- rtl/vcr_lead.sv -----
// Lead magnitudes of the two corner diagonals: normalize, divide by |u|^2, square root.
// Depends on vcr_pkg.
module vcr_lead
  import vcr_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [VEL_W-1:0] mag_x,
  input  logic [VEL_W-1:0] mag_y,
  input  logic             neg_x,
  input  logic             neg_y,
  output lead_t            lead
);

  logic [4:0]        len;
  logic [4:0]        sh;
  logic [VEL_W-1:0]  both;
  logic [U_W-1:0]    ux;
  logic [U_W-1:0]    uy;
  logic [P_W-1:0]    usum;
  logic [P_W-1:0]    udif;

  logic [U_W-1:0]    ux_r;
  logic [U_W-1:0]    uy_r;
  logic [P_W-1:0]    ps_r;
  logic [P_W-1:0]    pd_r;
  logic [Q_W-1:0]    q_r;
  logic [31:0]       num_r [2];

  logic [Q_W-1:0]    qd_r  [DIV_STEPS];
  logic [Q_W-1:0]    rem_r [2][DIV_STEPS];
  logic [Q_W-1:0]    quo_r [2][DIV_STEPS];
  logic [1:0]        lo_r  [2][DIV_STEPS];
  logic [Q_W-1:0]    sv_r  [2][LEAD_SQRT_STEPS];
  logic [31:0]       sr_r  [2][LEAD_SQRT_STEPS];
  logic [LEAD_W-1:0] lead_l [2];

  assign both = mag_x | mag_y;

  always_comb begin
    len = '0;
    for (int b = 0; b < VEL_W; b++) begin
      if (both[b]) len = 5'(b + 1);
    end
  end

  assign sh   = (len > 5'(U_W)) ? len - 5'(U_W) : '0;
  assign ux   = U_W'(mag_x >> sh);
  assign uy   = U_W'(mag_y >> sh);
  assign usum = {1'b0, ux} + {1'b0, uy};
  assign udif = (ux >= uy) ? {1'b0, ux - uy} : {1'b0, uy - ux};

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r     <= ux;
      uy_r     <= uy;
      ps_r     <= (neg_x == neg_y) ? usum : udif;
      pd_r     <= (neg_x == neg_y) ? udif : usum;
      q_r      <= Q_W'({16'b0, ux_r} * {16'b0, ux_r}) + Q_W'({16'b0, uy_r} * {16'b0, uy_r});
      num_r[0] <= {16'b0, ps_r} * {16'b0, ps_r};
      num_r[1] <= {16'b0, pd_r} * {16'b0, pd_r};
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_qd
    always_ff @(posedge clk) begin
      if (en) qd_r[g] <= (g == 0) ? q_r : qd_r[(g == 0) ? 0 : g - 1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // divide num * 2^29 by q: remainder starts at num >> 2, two live bits follow
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      logic [Q_W-1:0] r_in;
      logic [Q_W-1:0] qt_in;
      logic [1:0]     lo_in;
      logic [Q_W-1:0] d_in;
      logic           nb;
      logic [Q_W:0]   r2;
      if (g == 0) begin : g_first
        assign r_in  = {1'b0, num_r[l][31:2]};
        assign qt_in = '0;
        assign lo_in = num_r[l][1:0];
        assign d_in  = q_r;
      end else begin : g_next
        assign r_in  = rem_r[l][g-1];
        assign qt_in = quo_r[l][g-1];
        assign lo_in = lo_r[l][g-1];
        assign d_in  = qd_r[g-1];
      end
      assign nb = (g == 0) ? lo_in[1] : ((g == 1) ? lo_in[0] : 1'b0);
      assign r2 = {r_in, nb};
      always_ff @(posedge clk) begin
        if (en) begin
          lo_r[l][g] <= lo_in;
          if (r2 >= {1'b0, d_in}) begin
            rem_r[l][g] <= Q_W'(r2 - {1'b0, d_in});
            quo_r[l][g] <= {qt_in[Q_W-2:0], 1'b1};
          end else begin
            rem_r[l][g] <= r2[Q_W-1:0];
            quo_r[l][g] <= {qt_in[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    for (genvar g = 0; g < LEAD_SQRT_STEPS; g++) begin : g_sqrt
      localparam logic [31:0] BIT = 32'(1) << (2 * (LEAD_SQRT_STEPS - 1 - g));
      logic [Q_W-1:0] v_in;
      logic [31:0]    r_in;
      logic [31:0]    t;
      if (g == 0) begin : g_first
        assign v_in = quo_r[l][DIV_STEPS-1];
        assign r_in = '0;
      end else begin : g_next
        assign v_in = sv_r[l][g-1];
        assign r_in = sr_r[l][g-1];
      end
      assign t = r_in + BIT;
      always_ff @(posedge clk) begin
        if (en) begin
          if ({1'b0, v_in} >= t) begin
            sv_r[l][g] <= Q_W'({1'b0, v_in} - t);
            sr_r[l][g] <= (r_in >> 1) + BIT;
          end else begin
            sv_r[l][g] <= v_in;
            sr_r[l][g] <= r_in >> 1;
          end
        end
      end
    end

    assign lead_l[l] = (sr_r[l][LEAD_SQRT_STEPS-1] > {16'b0, LEAD_MAX}) ? LEAD_MAX :
                       sr_r[l][LEAD_SQRT_STEPS-1][LEAD_W-1:0];
  end

  assign lead.lsum = lead_l[0];
  assign lead.ldif = lead_l[1];

endmodule

// ----- rtl/velocity_corner_radius_unit.sv -----
// Top level of the velocity corner radius unit: config registers, input/output stages,
// alignment delays and the final radius arithmetic. Depends on vcr_pkg, vcr_speed,
// vcr_power and vcr_lead.
//
// Usage:
//   in_*  : one transfer carries a signed Q16.8 velocity vector (x in the low 24 bits).
//   out_* : one transfer per input carries four Q8.8 corner radii.
//   cfg_* : register writes (index 0..5), always ready; indexes 6 and 7 are dropped.
//           Write only while no item is in flight.
// Throughput: one item per cycle unless the output stalls. The whole pipeline moves
//   as one; every stage carries a valid bit, so bubbles simply pass through.
// Stall: while out_tvalid is high and out_tready low, every stage holds and
//   in_tready drops; nothing is lost or repeated.
// Reset (rst_n low at a clock edge): all valid bits clear and the registers
//   take their defaults (rest 8.0, min 0, max 255.996, spread 4.0,
//   reference speed 1000.0, exponent 1.0).
// Depth: squarer 2, speed root 24, divider 16, log 17, exponent scale 2,
//   exp 17, radius multiplies 2, input and output register 1 each.
module velocity_corner_radius_unit
  import vcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // [23:0] velocity_x, [47:24] velocity_y
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,  // [15:0] radius_top_left, [31:16] radius_top_right,
                                            // [47:32] radius_bottom_right,
                                            // [63:48] radius_bottom_left
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [RAD_W-1:0]  rest_r;
  logic [RAD_W-1:0]  min_r;
  logic [RAD_W-1:0]  max_r;
  logic [RAD_W-1:0]  spread_r;
  logic [VREF_W-1:0] vref_r;
  logic [GAM_W-1:0]  gamma_r;
  logic [VREF_W-1:0] vref_eff;

  logic              adv;
  logic              vld_r [PIPE_DEPTH];

  // input stage
  logic [VEL_W-1:0]  vx;
  logic [VEL_W-1:0]  vy;
  logic [VEL_W:0]    negx;
  logic [VEL_W:0]    negy;
  logic [VEL_W:0]    vsum;
  logic [VEL_W:0]    vdif;
  logic [VEL_W-1:0]  ax_r;
  logic [VEL_W-1:0]  ay_r;
  logic              nx_r;
  logic              ny_r;
  side_t             side_r;
  side_t             side_d_r [PIPE_DEPTH-2];

  logic [K_W-1:0]    k_lin;
  logic [K_W-1:0]    k_pow;
  lead_t             lead;
  lead_t             lead_d_r [LEAD_DLY];

  // radius multiplies
  logic [31:0]       ls_sum_r;
  logic [31:0]       ls_dif_r;
  logic [K_W-1:0]    k_m_r;
  logic [48:0]       pr_sum_r;
  logic [48:0]       pr_dif_r;

  logic [16:0]       d_sum;
  logic [16:0]       d_dif;
  logic [49:0]       rnd_sum;
  logic [49:0]       rnd_dif;
  side_t             side_o;
  logic [63:0]       out_nxt;
  logic [63:0]       out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r   <= REST_RST;
      min_r    <= MIN_RST;
      max_r    <= MAX_RST;
      spread_r <= SPRD_RST;
      vref_r   <= VREF_RST;
      gamma_r  <= GAMMA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REST:   rest_r   <= cfg_data[RAD_W-1:0];
        REG_MIN:    min_r    <= cfg_data[RAD_W-1:0];
        REG_MAX:    max_r    <= cfg_data[RAD_W-1:0];
        REG_SPREAD: spread_r <= cfg_data[RAD_W-1:0];
        REG_VREF:   vref_r   <= cfg_data[VREF_W-1:0];
        REG_GAMMA:  gamma_r  <= cfg_data[GAM_W-1:0];
        default:    ;
      endcase
    end
  end

  // reference speeds below 1.0 act as 1.0
  assign vref_eff = (vref_r < VREF_MIN) ? VREF_MIN : vref_r;

  // whole pipeline advances unless the output holds an untaken result
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PIPE_DEPTH; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int s = 1; s < PIPE_DEPTH; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  assign vx   = in_tdata[VEL_W-1:0];
  assign vy   = in_tdata[2*VEL_W-1:VEL_W];
  assign negx = {(VEL_W+1){1'b0}} - {vx[VEL_W-1], vx};
  assign negy = {(VEL_W+1){1'b0}} - {vy[VEL_W-1], vy};
  assign vsum = {vx[VEL_W-1], vx} + {vy[VEL_W-1], vy};
  assign vdif = {vx[VEL_W-1], vx} - {vy[VEL_W-1], vy};

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r           <= vx[VEL_W-1] ? negx[VEL_W-1:0] : vx;
      ay_r           <= vy[VEL_W-1] ? negy[VEL_W-1:0] : vy;
      nx_r           <= vx[VEL_W-1];
      ny_r           <= vy[VEL_W-1];
      side_r.zero    <= (vx == '0) && (vy == '0);
      side_r.sum_neg <= vsum[VEL_W];
      side_r.sum_pos <= !vsum[VEL_W] && (vsum != '0);
      side_r.dif_neg <= vdif[VEL_W];
      side_r.dif_pos <= !vdif[VEL_W] && (vdif != '0);
      side_d_r[0]    <= side_r;
      for (int s = 1; s < PIPE_DEPTH - 2; s++) side_d_r[s] <= side_d_r[s-1];
    end
  end

  vcr_speed u_speed (
    .clk   (clk),
    .en    (adv),
    .mag_x (ax_r),
    .mag_y (ay_r),
    .vref  (vref_eff),
    .k_lin (k_lin)
  );

  vcr_power u_power (
    .clk   (clk),
    .en    (adv),
    .k_lin (k_lin),
    .gamma (gamma_r),
    .k_out (k_pow)
  );

  vcr_lead u_lead (
    .clk   (clk),
    .en    (adv),
    .mag_x (ax_r),
    .mag_y (ay_r),
    .neg_x (nx_r),
    .neg_y (ny_r),
    .lead  (lead)
  );

  // lead is ready well before liquidity; line it up
  always_ff @(posedge clk) begin
    if (adv) begin
      lead_d_r[0] <= lead;
      for (int s = 1; s < LEAD_DLY; s++) lead_d_r[s] <= lead_d_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ls_sum_r <= {16'b0, lead_d_r[LEAD_DLY-1].lsum} * {16'b0, spread_r};
      ls_dif_r <= {16'b0, lead_d_r[LEAD_DLY-1].ldif} * {16'b0, spread_r};
      k_m_r    <= k_pow;
      pr_sum_r <= {17'b0, ls_sum_r} * {32'b0, k_m_r};
      pr_dif_r <= {17'b0, ls_dif_r} * {32'b0, k_m_r};
    end
  end

  // round half up, then drop 31 fraction bits
  assign rnd_sum = {1'b0, pr_sum_r} + (50'd1 << 30);
  assign rnd_dif = {1'b0, pr_dif_r} + (50'd1 << 30);
  assign d_sum   = rnd_sum[47:31];
  assign d_dif   = rnd_dif[47:31];
  assign side_o  = side_d_r[PIPE_DEPTH-3];

  function automatic logic [RAD_W-1:0] corner(input logic sub, input logic [16:0] d,
                                              input logic [RAD_W-1:0] rest,
                                              input logic [RAD_W-1:0] lo,
                                              input logic [RAD_W-1:0] hi);
    logic signed [18:0] r;
    logic [RAD_W-1:0]   res;
    r = sub ? $signed({3'b0, rest}) - $signed({2'b0, d})
            : $signed({3'b0, rest}) + $signed({2'b0, d});
    if (r < $signed({3'b0, lo}))      res = lo;
    else if (r > $signed({3'b0, hi})) res = hi;
    else                              res = r[RAD_W-1:0];
    return res;
  endfunction

  always_comb begin
    if (side_o.zero) begin
      out_nxt = {rest_r, rest_r, rest_r, rest_r};
    end else begin
      out_nxt = {corner(side_o.dif_neg, d_dif, rest_r, min_r, max_r),
                 corner(side_o.sum_pos, d_sum, rest_r, min_r, max_r),
                 corner(side_o.dif_pos, d_dif, rest_r, min_r, max_r),
                 corner(side_o.sum_neg, d_sum, rest_r, min_r, max_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule
